### sv/p2g_pkg.sv
package p2g_pkg;

    // Pixel format codes carried on opcode
    localparam logic [2:0] OP_GRAY8  = 3'd0;
    localparam logic [2:0] OP_GRAY8A = 3'd1;
    localparam logic [2:0] OP_GRAY16 = 3'd2;
    localparam logic [2:0] OP_GRAY32 = 3'd3;
    localparam logic [2:0] OP_GRAY64 = 3'd4;
    localparam logic [2:0] OP_RGB8   = 3'd5;
    localparam logic [2:0] OP_RGBA8  = 3'd6;

    // Work classes handed from the front end to the datapath
    localparam logic [1:0] CLS_PASS  = 2'd0;
    localparam logic [1:0] CLS_GRAYA = 2'd1;
    localparam logic [1:0] CLS_RGB   = 2'd2;
    localparam logic [1:0] CLS_RGBA  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_BG      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BG       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BG     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BG      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESCALE      = 4'd7;

    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_RED_WEIGHT   = 16'd4899;
    localparam logic [15:0] RST_GREEN_WEIGHT = 16'd9617;
    localparam logic [15:0] RST_BLUE_WEIGHT  = 16'd1868;

    localparam int P2G_WEIGHT_FRAC_BITS = 14;

    // Weighted sum: three 8x16 products plus rounding constant
    localparam int SUM_W = 26;

    // Entries in the queue between front end and datapath
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] alpha;
    } p2g_item_t;

    typedef struct packed {
        logic [15:0] red_weight;
        logic [15:0] green_weight;
        logic [15:0] blue_weight;
        logic [7:0]  gray_bg;
        logic [7:0]  red_bg;
        logic [7:0]  grn_bg;
        logic [7:0]  blue_bg;
    } p2g_cfg_t;

    // Divide a value below 65280 by 255 (shift-add reciprocal)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] y;
        y = x + {8'd0, x[15:8]} + 16'd1;
        return y[15:8];
    endfunction

endpackage

### sv/p2g_front.sv
module p2g_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          opcode,
    input  logic [63:0]         channel_zero,
    input  logic [7:0]          channel_one,
    input  logic [7:0]          channel_two,
    input  logic [7:0]          channel_three,
    input  logic                rescale,
    input  logic                q_full,
    output logic                push,
    output p2g_pkg::p2g_item_t  push_item
);
    import p2g_pkg::*;

    logic      fr_valid_reg;
    logic      fr_valid_next;
    p2g_item_t fr_item_reg;
    p2g_item_t decoded;
    logic      accept;

    // Hand the held word to the queue when it has room
    assign push      = fr_valid_reg && !q_full;
    assign busy      = fr_valid_reg && q_full;
    assign accept    = start && !busy;
    assign push_item = fr_item_reg;

    // Classify the pixel and pick out its bytes
    always_comb
    begin
        decoded.cls   = CLS_PASS;
        decoded.byte0 = 8'd0;
        decoded.byte1 = channel_one;
        decoded.byte2 = channel_two;
        decoded.alpha = channel_three;
        case (opcode)
            OP_GRAY8:
            begin
                decoded.byte0 = channel_zero[7:0];
            end
            OP_GRAY8A:
            begin
                decoded.cls   = CLS_GRAYA;
                decoded.byte0 = channel_zero[7:0];
                decoded.alpha = channel_one;
            end
            OP_GRAY16:
            begin
                decoded.byte0 = rescale ? channel_zero[15:8] : channel_zero[7:0];
            end
            OP_GRAY32:
            begin
                decoded.byte0 = rescale ? channel_zero[31:24] : channel_zero[7:0];
            end
            OP_GRAY64:
            begin
                decoded.byte0 = rescale ? channel_zero[63:56] : channel_zero[7:0];
            end
            OP_RGB8:
            begin
                decoded.cls   = CLS_RGB;
                decoded.byte0 = channel_zero[7:0];
            end
            OP_RGBA8:
            begin
                decoded.cls   = CLS_RGBA;
                decoded.byte0 = channel_zero[7:0];
            end
            default:
            begin
                decoded.byte0 = 8'd0;
            end
        endcase
    end

    // Hold a word until the queue takes it
    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_item_reg <= decoded;
        end
    end

endmodule

### sv/p2g_queue.sv
module p2g_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  p2g_pkg::p2g_item_t  push_item,
    input  logic                pop,
    output p2g_pkg::p2g_item_t  pop_item,
    output logic                full,
    output logic                empty
);
    import p2g_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    p2g_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");
`endif

endmodule

### sv/p2g_back.sv
module p2g_back #(
    parameter int WEIGHT_FRAC_BITS = p2g_pkg::P2G_WEIGHT_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  p2g_pkg::p2g_cfg_t   cfg,
    input  logic                in_valid,
    input  p2g_pkg::p2g_item_t  in_item,
    output logic [7:0]          gray_value,
    output logic                done
);
    import p2g_pkg::*;

    localparam logic [SUM_W-1:0] ROUND_ADD =
        {{(SUM_W-1){1'b0}}, 1'b1} << (WEIGHT_FRAC_BITS - 1);

    // Stage 1: blend products
    logic        s1_valid_reg;
    logic [1:0]  s1_cls_reg;
    logic [7:0]  s1_raw_reg [3];
    logic [15:0] s1_num_reg [3];
    logic [15:0] s1_num_next [3];
    logic [7:0]  lane_in [3];
    logic [7:0]  lane_bg [3];
    logic [7:0]  inv_alpha;

    // Stage 2: blended or raw channel bytes
    logic        s2_valid_reg;
    logic [1:0]  s2_cls_reg;
    logic [7:0]  s2_lane_reg [3];
    logic [7:0]  s2_lane_next [3];

    // Stage 3: weighted products
    logic        s3_valid_reg;
    logic [1:0]  s3_cls_reg;
    logic [7:0]  s3_byte_reg;
    logic [23:0] s3_prod_reg [3];

    // Stage 4: sum, round, saturate
    logic [SUM_W-1:0] sum_rounded;
    logic [SUM_W-1:0] sum_shifted;
    logic [7:0]       weighted;
    logic [7:0]       out_next;
    logic             done_reg;
    logic [7:0]       gray_reg;

    // Form blend numerators per lane
    assign lane_in[0] = in_item.byte0;
    assign lane_in[1] = in_item.byte1;
    assign lane_in[2] = in_item.byte2;
    assign lane_bg[0] = (in_item.cls == CLS_GRAYA) ? cfg.gray_bg : cfg.red_bg;
    assign lane_bg[1] = cfg.grn_bg;
    assign lane_bg[2] = cfg.blue_bg;
    assign inv_alpha  = 8'd255 - in_item.alpha;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_num_next[i] = ({8'd0, lane_in[i]} * {8'd0, in_item.alpha})
                           + ({8'd0, lane_bg[i]} * {8'd0, inv_alpha});
        end
    end

    // Round and divide by 255 where the class blends
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s1_cls_reg inside {CLS_GRAYA, CLS_RGBA})
            begin
                s2_lane_next[i] = div255(s1_num_reg[i] + 16'd127);
            end
            else
            begin
                s2_lane_next[i] = s1_raw_reg[i];
            end
        end
    end

    // Sum weighted channels, round half up, clamp
    assign sum_rounded = {2'b00, s3_prod_reg[0]} + {2'b00, s3_prod_reg[1]}
                       + {2'b00, s3_prod_reg[2]} + ROUND_ADD;
    assign sum_shifted = sum_rounded >> WEIGHT_FRAC_BITS;
    assign weighted    = (|sum_shifted[SUM_W-1:8]) ? 8'hFF : sum_shifted[7:0];

    always_comb
    begin
        case (s3_cls_reg)
            CLS_RGB, CLS_RGBA: out_next = weighted;
            default:           out_next = s3_byte_reg;
        endcase
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        s1_cls_reg <= in_item.cls;
        s2_cls_reg <= s1_cls_reg;
        s3_cls_reg <= s2_cls_reg;
        s3_byte_reg <= s2_lane_reg[0];
        gray_reg   <= out_next;
        for (int i = 0; i < 3; i++)
        begin
            s1_raw_reg[i]  <= lane_in[i];
            s1_num_reg[i]  <= s1_num_next[i];
            s2_lane_reg[i] <= s2_lane_next[i];
        end
        s3_prod_reg[0] <= {16'd0, s2_lane_reg[0]} * {8'd0, cfg.red_weight};
        s3_prod_reg[1] <= {16'd0, s2_lane_reg[1]} * {8'd0, cfg.green_weight};
        s3_prod_reg[2] <= {16'd0, s2_lane_reg[2]} * {8'd0, cfg.blue_weight};
    end

    assign gray_value = gray_reg;
    assign done       = done_reg;

`ifndef SYNTH
    a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##4 done)
        else $error("result did not leave four cycles after pop");

    a_no_spurious_done : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s3_valid_reg))
        else $error("result strobe without a word in the last stage");
`endif

endmodule

### sv/pixel_to_gray8_converter_top.sv
// Pixel to 8-bit gray converter.
//
// Input: drive opcode and the channel ports with start high; a word is taken
// at each rising edge with start high and busy low. One pixel per clock is
// sustained. Opcode selects gray8, gray8 with alpha, gray16/32/64, rgb8 or
// rgba8; an unused code yields gray 0.
// Output: each word gives exactly one gray_value, shown for one cycle with
// done high. The result passes the classify register, one queue slot,
// then four datapath stages (blend multiply, divide by 255, weight
// multiply, sum and clamp).
// The receiver cannot stall; the datapath never stops, so the queue drains
// every cycle and busy only rises if the queue were ever full.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no pixel is in flight.
// Reset: rst_n clears the pipeline and queue and loads the default weights,
// zero backgrounds and rescale on.
module pixel_to_gray8_converter_top #(
    parameter int WEIGHT_FRAC_BITS = p2g_pkg::P2G_WEIGHT_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       opcode,
    input  logic [63:0]                      channel_zero,
    input  logic [7:0]                       channel_one,
    input  logic [7:0]                       channel_two,
    input  logic [7:0]                       channel_three,
    output logic [7:0]                       gray_value,
    output logic                             done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [p2g_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [p2g_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import p2g_pkg::*;

    logic [15:0] red_weight_reg;
    logic [15:0] green_weight_reg;
    logic [15:0] blue_weight_reg;
    logic [7:0]  gray_bg_reg;
    logic [7:0]  red_bg_reg;
    logic [7:0]  grn_bg_reg;
    logic [7:0]  blue_bg_reg;
    logic        rescale_reg;
    logic        cfg_write;
    p2g_cfg_t    cfg;

    logic        push;
    p2g_item_t   push_item;
    p2g_item_t   pop_item;
    logic        q_full;
    logic        q_empty;
    logic        pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Load configuration registers; unknown indexes drop the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_weight_reg   <= RST_RED_WEIGHT;
            green_weight_reg <= RST_GREEN_WEIGHT;
            blue_weight_reg  <= RST_BLUE_WEIGHT;
            gray_bg_reg      <= 8'd0;
            red_bg_reg       <= 8'd0;
            grn_bg_reg       <= 8'd0;
            blue_bg_reg      <= 8'd0;
            rescale_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RED_WEIGHT:   red_weight_reg   <= cfg_data[15:0];
                REG_GREEN_WEIGHT: green_weight_reg <= cfg_data[15:0];
                REG_BLUE_WEIGHT:  blue_weight_reg  <= cfg_data[15:0];
                REG_GRAY_BG:      gray_bg_reg      <= cfg_data[7:0];
                REG_RED_BG:       red_bg_reg       <= cfg_data[7:0];
                REG_GREEN_BG:     grn_bg_reg       <= cfg_data[7:0];
                REG_BLUE_BG:      blue_bg_reg      <= cfg_data[7:0];
                REG_RESCALE:      rescale_reg      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg.red_weight   = red_weight_reg;
    assign cfg.green_weight = green_weight_reg;
    assign cfg.blue_weight  = blue_weight_reg;
    assign cfg.gray_bg      = gray_bg_reg;
    assign cfg.red_bg       = red_bg_reg;
    assign cfg.grn_bg       = grn_bg_reg;
    assign cfg.blue_bg      = blue_bg_reg;

    // Datapath takes a word every cycle the queue has one
    assign pop = !q_empty;

    p2g_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .channel_zero  (channel_zero),
        .channel_one   (channel_one),
        .channel_two   (channel_two),
        .channel_three (channel_three),
        .rescale       (rescale_reg),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    p2g_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    p2g_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (pop),
        .in_item    (pop_item),
        .gray_value (gray_value),
        .done       (done)
    );

`ifndef SYNTH
    a_accept_reaches_output : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !q_full) |-> ##6 done)
        else $error("accepted pixel did not produce a result on time");
`endif

endmodule

### tb/testbench.sv
module testbench;
    import p2g_pkg::*;

    localparam int         CLK_HALF      = 5;
    localparam int         PIPE_LATENCY  = 6;
    localparam int         SETTLE_CYCLES = 2 * PIPE_LATENCY + 4;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         FRAC          = P2G_WEIGHT_FRAC_BITS;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            opcode;
    logic [63:0]           channel_zero;
    logic [7:0]            channel_one;
    logic [7:0]            channel_two;
    logic [7:0]            channel_three;
    logic [7:0]            gray_value;
    logic                  done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the block's configuration registers
    logic [15:0] red_wt;
    logic [15:0] green_wt;
    logic [15:0] blue_wt;
    logic [7:0]  gray_bg;
    logic [7:0]  red_bg;
    logic [7:0]  grn_bg;
    logic [7:0]  blue_bg;
    logic        rescale_on;

    logic [7:0]  expected_grays[$];
    logic [7:0]  gray_want;
    int          errors;
    int          cycle_count;
    int          sender_idle_pct;

    pixel_to_gray8_converter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .channel_zero  (channel_zero),
        .channel_one   (channel_one),
        .channel_two   (channel_two),
        .channel_three (channel_three),
        .gray_value    (gray_value),
        .done          (done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Blend one 8-bit colour over a background, rounded half up
    function automatic logic [7:0] blend_over(input logic [7:0] c, input logic [7:0] a,
                                              input logic [7:0] bg);
        int unsigned num;
        num = c * a + bg * (255 - a);
        return 8'((num + 127) / 255);
    endfunction

    // Weight three channels, round half up and clamp at 255
    function automatic logic [7:0] weighted_gray(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        longint unsigned acc;
        acc = r * red_wt + g * green_wt + b * blue_wt;
        acc = (acc + (64'd1 << (FRAC - 1))) >> FRAC;
        return (acc > 255) ? 8'hFF : 8'(acc);
    endfunction

    // Keep the top or the low byte of a wide gray value
    function automatic logic [7:0] wide_gray_byte(input logic [63:0] v, input int bits);
        logic [63:0] x;
        x = v;
        if (bits < 64)
            x = x & ((64'd1 << bits) - 64'd1);
        if (rescale_on)
            x = x >> (bits - 8);
        return x[7:0];
    endfunction

    function automatic logic [7:0] predict_gray(input logic [2:0] op, input logic [63:0] c0,
                                                input logic [7:0] c1, input logic [7:0] c2,
                                                input logic [7:0] c3);
        case (op)
            OP_GRAY8:  return c0[7:0];
            OP_GRAY8A: return blend_over(c0[7:0], c1, gray_bg);
            OP_GRAY16: return wide_gray_byte(c0, 16);
            OP_GRAY32: return wide_gray_byte(c0, 32);
            OP_GRAY64: return wide_gray_byte(c0, 64);
            OP_RGB8:   return weighted_gray(c0[7:0], c1, c2);
            OP_RGBA8:  return weighted_gray(blend_over(c0[7:0], c3, red_bg),
                                            blend_over(c1, c3, grn_bg),
                                            blend_over(c2, c3, blue_bg));
            default:   return 8'h00;
        endcase
    endfunction

    // Check each gray word against the oldest prediction
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (expected_grays.size() == 0)
            begin
                $error("gray_value: expected none, actual %0d", gray_value);
                errors++;
            end
            else
            begin
                gray_want = expected_grays.pop_front();
                if (gray_value !== gray_want)
                begin
                    $error("gray_value: expected %0d, actual %0d", gray_want, gray_value);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pixel_to_gray8_converter_top: mismatch");
            $finish;
        end
    end

    // Send one pixel word, idling a random number of cycles ahead of it
    task automatic send_pixel(input logic [2:0] op, input logic [63:0] c0,
                              input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start         <= 1'b1;
        opcode        <= op;
        channel_zero  <= c0;
        channel_one   <= c1;
        channel_two   <= c2;
        channel_three <= c3;
        do
            @(posedge clk);
        while (busy);
        expected_grays.push_back(predict_gray(op, c0, c1, c2, c3));
    endtask

    // Drop start and hold until every gray word is back and the pipe is empty
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_grays.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RED_WEIGHT:   red_wt     = data;
            REG_GREEN_WEIGHT: green_wt   = data;
            REG_BLUE_WEIGHT:  blue_wt    = data;
            REG_GRAY_BG:      gray_bg    = data[7:0];
            REG_RED_BG:       red_bg     = data[7:0];
            REG_GREEN_BG:     grn_bg     = data[7:0];
            REG_BLUE_BG:      blue_bg    = data[7:0];
            REG_RESCALE:      rescale_on = data[0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 12000));
        endcase
    endfunction

    task automatic randomize_config();
        write_reg(REG_RED_WEIGHT, pick_weight());
        write_reg(REG_GREEN_WEIGHT, pick_weight());
        write_reg(REG_BLUE_WEIGHT, pick_weight());
        write_reg(REG_GRAY_BG, 16'($urandom));
        write_reg(REG_RED_BG, 16'($urandom));
        write_reg(REG_GREEN_BG, 16'($urandom));
        write_reg(REG_BLUE_BG, 16'($urandom));
        write_reg(REG_RESCALE, 16'($urandom));
        write_reg(4'($urandom_range(REG_RESCALE + 1, 15)), 16'($urandom));
    endtask

    task automatic send_random_pixel();
        logic [2:0]  op;
        logic [63:0] c0;
        logic [7:0]  alpha;
        logic [7:0]  c1;
        op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        c0 = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       c0 = '0;
            1:       c0 = '1;
            2:       c0 = c0 >> $urandom_range(0, 63);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0:       alpha = 8'h00;
            1:       alpha = 8'hFF;
            default: alpha = 8'($urandom);
        endcase
        // Gray8a takes its alpha on channel one
        c1 = (op == OP_GRAY8A) ? alpha : 8'($urandom);
        send_pixel(op, c0, c1, 8'($urandom), alpha);
    endtask

    // Reset weights: byte extremes, high bits to drop, opaque and clear alpha
    task automatic test_reset_defaults();
        send_pixel(OP_GRAY8, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(OP_GRAY8, 64'h0000_0000_0000_00FF, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_GRAY16, 64'hFFFF_FFFF_FFFF_00FF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(OP_GRAY16, 64'h0000_0000_0000_FF00, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_GRAY32, 64'hFFFF_FFFF_00FF_FFFF, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_GRAY32, 64'h0000_0000_FF00_0000, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(OP_GRAY64, 64'hFF00_0000_0000_0000, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_GRAY64, 64'h00FF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(OP_GRAY8A, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hFF, 8'hFF);
        send_pixel(OP_GRAY8A, 64'h0000_0000_0000_00C8, 8'h80, 8'h00, 8'h00);
        send_pixel(OP_RGB8, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'h00);
        send_pixel(OP_RGB8, 64'hFFFF_FFFF_FFFF_FF00, 8'h00, 8'h00, 8'hFF);
        send_pixel(OP_RGBA8, 64'h0000_0000_0000_00FF, 8'hFF, 8'hFF, 8'h00);
        send_pixel(OP_RGBA8, 64'h0000_0000_0000_00FF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(OP_RGBA8, 64'h0000_0000_0000_0040, 8'h80, 8'hC0, 8'h7F);
        send_pixel(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();
    endtask

    // Register extremes, dropped high data bits and writes past the last index
    task automatic test_register_extremes();
        write_reg(REG_RESCALE, 16'hFFFE);
        write_reg(REG_RED_WEIGHT, 16'hFFFF);
        write_reg(REG_GREEN_WEIGHT, 16'hFFFF);
        write_reg(REG_BLUE_WEIGHT, 16'hFFFF);
        write_reg(REG_GRAY_BG, 16'hFFFF);
        write_reg(REG_RED_BG, 16'hFFFF);
        write_reg(REG_GREEN_BG, 16'hFFFF);
        write_reg(REG_BLUE_BG, 16'hFFFF);
        for (int i = REG_RESCALE + 1; i < 16; i++)
            write_reg(4'(i), 16'h0000);
        send_pixel(OP_GRAY16, 64'hFFFF_FFFF_FFFF_1234, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_GRAY64, 64'h8000_0000_0000_0081, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_GRAY8A, 64'h0000_0000_0000_0000, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_RGB8, 64'h0000_0000_0000_0001, 8'h00, 8'h00, 8'h00);
        send_pixel(OP_RGBA8, 64'h0000_0000_0000_0000, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(REG_RED_WEIGHT, 16'h0000);
        write_reg(REG_GREEN_WEIGHT, 16'h0000);
        write_reg(REG_BLUE_WEIGHT, 16'h0000);
        write_reg(REG_GRAY_BG, 16'hFF00);
        write_reg(REG_RED_BG, 16'h0100);
        write_reg(REG_GREEN_BG, 16'h0100);
        write_reg(REG_BLUE_BG, 16'h0100);
        write_reg(REG_RESCALE, 16'h0001);
        send_pixel(OP_RGB8, 64'h0000_0000_0000_00FF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(OP_RGBA8, 64'h0000_0000_0000_00FF, 8'hFF, 8'hFF, 8'h80);
        send_pixel(OP_GRAY8A, 64'h0000_0000_0000_00FF, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    // Random pixels in chunks, each chunk under a fresh configuration
    task automatic test_random_traffic(input int idle_pct, input int chunks, input int chunk_len);
        sender_idle_pct = idle_pct;
        repeat (chunks)
        begin
            randomize_config();
            repeat (chunk_len) send_random_pixel();
            wait_idle();
        end
    endtask

    initial
    begin
        errors          = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = OP_GRAY8;
        channel_zero    = '0;
        channel_one     = '0;
        channel_two     = '0;
        channel_three   = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_RED_WEIGHT;
        cfg_data        = '0;
        red_wt          = RST_RED_WEIGHT;
        green_wt        = RST_GREEN_WEIGHT;
        blue_wt         = RST_BLUE_WEIGHT;
        gray_bg         = 8'h00;
        red_bg          = 8'h00;
        grn_bg          = 8'h00;
        blue_bg         = 8'h00;
        rescale_on      = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(28, 4, 50);
        test_random_traffic(79, 4, 50);
        test_random_traffic(0, 4, 50);

        if (errors == 0)
            $display("pixel_to_gray8_converter_top: match");
        else
            $display("pixel_to_gray8_converter_top: mismatch");
        $finish;
    end

endmodule
